[rtl/u8c_pkg.sv]
// shared types, constants and helper functions of the utf-8 line/word/char counter
`default_nettype none
package u8c_pkg;

  localparam int COUNT_BITS = 48;
  localparam int FIELD_W    = 48;
  localparam int CLIP_W     = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

  localparam int LINE_LSB = 0;
  localparam int WORD_LSB = LINE_LSB + FIELD_W;
  localparam int CHAR_LSB = WORD_LSB + FIELD_W;
  localparam int LONG_LSB = CHAR_LSB + FIELD_W;
  localparam int INV_BIT  = LONG_LSB + FIELD_W;
  localparam int FIL_LSB  = INV_BIT + 1;
  localparam int PAY_W    = FIL_LSB + FIELD_W;
  localparam int OUT_W    = ((PAY_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_UTF8   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NBSP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIGSP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NNBSP  = 3'd4;

  typedef logic [COUNT_BITS-1:0] count_t;

  // partial matches of multi-byte unicode spaces
  typedef enum logic [3:0] {
    MS_IDLE,
    MS_C2,
    MS_E1,
    MS_E1_9A,
    MS_E2,
    MS_E2_80,
    MS_E2_81,
    MS_E3,
    MS_E3_80
  } match_t;

  typedef struct packed {
    logic utf8_enable;
    logic chars_as_characters;
    logic nbsp_is_space;
    logic figure_space_is_space;
    logic narrow_nbsp_is_space;
  } cfg_t;

  typedef struct packed {
    count_t     lines;
    count_t     words;
    count_t     bytes;
    count_t     conts;
    count_t     cur_len;
    count_t     max_len;
    count_t     err_line;
    logic       in_word;
    logic [2:0] pend;
    match_t     match;
    logic       err;
  } state_t;

  function automatic count_t bump(count_t v);
    bump = (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic logic [FIELD_W-1:0] clip(count_t v);
    logic [CLIP_W-1:0] w;
    logic [CLIP_W-1:0] m;
    w = CLIP_W'(v);
    m = CLIP_W'({FIELD_W{1'b1}});
    if (w > m) clip = {FIELD_W{1'b1}};
    else clip = FIELD_W'(w);
  endfunction

  function automatic logic ascii_space(logic [7:0] b);
    ascii_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic match_t match_next(match_t st, logic [7:0] b);
    match_next = MS_IDLE;
    if (st == MS_E1 && b == 8'h9a) match_next = MS_E1_9A;
    if (st == MS_E2 && b == 8'h80) match_next = MS_E2_80;
    if (st == MS_E2 && b == 8'h81) match_next = MS_E2_81;
    if (st == MS_E3 && b == 8'h80) match_next = MS_E3_80;
  endfunction

  function automatic logic match_final(match_t st, logic [7:0] b, cfg_t c);
    match_final = 1'b0;
    unique case (st)
      MS_C2:    match_final = (b == 8'h85 || b == 8'ha0) && c.nbsp_is_space;
      MS_E1_9A: match_final = (b == 8'h80);
      MS_E2_80: begin
        if (b == 8'h87) match_final = c.figure_space_is_space;
        else if (b >= 8'h80 && b <= 8'h8b) match_final = 1'b1;
        else if (b == 8'ha8 || b == 8'ha9) match_final = 1'b1;
        else if (b == 8'haf) match_final = c.narrow_nbsp_is_space;
      end
      MS_E2_81: match_final = (b == 8'h9f);
      MS_E3_80: match_final = (b == 8'h80);
      default:  match_final = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/u8c_step.sv]
// per-byte utf-8 decode and counter next-state logic
`default_nettype none
module u8c_step (
  input  var u8c_pkg::state_t st,
  input  var u8c_pkg::cfg_t   cfg,
  input  wire logic [7:0]     byte_i,
  input  wire logic           has_i,
  input  wire logic           eos_i,
  output u8c_pkg::state_t     nxt
);

  // word tracking: returns {in_word, word_bump}
  function automatic logic [1:0] wcall(logic iw, logic wb, logic sp);
    if (sp) wcall = {1'b0, wb};
    else wcall = {1'b1, wb | ~iw};
  endfunction

  always_comb begin
    logic       iw;
    logic       wb;
    logic       fl;
    logic       bytes_inc;
    logic       cont_inc;
    logic       nl;
    logic       len_inc;
    logic [2:0] pend;
    u8c_pkg::match_t match;
    logic [1:0] w;

    iw        = st.in_word;
    wb        = 1'b0;
    fl        = 1'b0;
    bytes_inc = 1'b0;
    cont_inc  = 1'b0;
    nl        = 1'b0;
    len_inc   = 1'b0;
    pend      = st.pend;
    match     = st.match;
    w         = 2'b00;

    if (has_i) begin
      if (!cfg.utf8_enable) begin
        pend      = 3'd0;
        match     = u8c_pkg::MS_IDLE;
        bytes_inc = 1'b1;
        if (byte_i == 8'h0a) nl = 1'b1;
        else len_inc = 1'b1;
        w  = wcall(iw, wb, u8c_pkg::ascii_space(byte_i));
        iw = w[1];
        wb = w[0];
      end else if (byte_i[7:6] == 2'b10) begin
        bytes_inc = 1'b1;
        cont_inc  = 1'b1;
        if (pend == 3'd0) begin
          fl = 1'b1;
          w  = wcall(iw, wb, 1'b0);
          iw = w[1];
          wb = w[0];
        end else begin
          pend = pend - 3'd1;
          if (pend == 3'd0) begin
            w     = wcall(iw, wb, u8c_pkg::match_final(match, byte_i, cfg));
            iw    = w[1];
            wb    = w[0];
            match = u8c_pkg::MS_IDLE;
          end else begin
            match = u8c_pkg::match_next(match, byte_i);
          end
        end
      end else begin
        if (pend != 3'd0) begin
          fl    = 1'b1;
          w     = wcall(iw, wb, 1'b0);
          iw    = w[1];
          wb    = w[0];
          pend  = 3'd0;
          match = u8c_pkg::MS_IDLE;
        end
        bytes_inc = 1'b1;
        if (byte_i == 8'h0a) begin
          nl = 1'b1;
          w  = wcall(iw, wb, 1'b1);
          iw = w[1];
          wb = w[0];
        end else begin
          len_inc = 1'b1;
          if (byte_i < 8'h80) begin
            w  = wcall(iw, wb, u8c_pkg::ascii_space(byte_i));
            iw = w[1];
            wb = w[0];
          end else if (byte_i == 8'hc0 || byte_i == 8'hc1 ||
                       byte_i == 8'hfe || byte_i == 8'hff) begin
            fl = 1'b1;
            w  = wcall(iw, wb, 1'b0);
            iw = w[1];
            wb = w[0];
          end else begin
            priority if (byte_i < 8'he0) pend = 3'd1;
            else if (byte_i < 8'hf0) pend = 3'd2;
            else if (byte_i < 8'hf8) pend = 3'd3;
            else if (byte_i < 8'hfc) pend = 3'd4;
            else pend = 3'd5;
            priority if (byte_i == 8'hc2) match = u8c_pkg::MS_C2;
            else if (byte_i == 8'he1) match = u8c_pkg::MS_E1;
            else if (byte_i == 8'he2) match = u8c_pkg::MS_E2;
            else if (byte_i == 8'he3) match = u8c_pkg::MS_E3;
            else match = u8c_pkg::MS_IDLE;
          end
        end
      end
    end

    // sequence still open at end of stream
    if (eos_i && pend != 3'd0) begin
      fl    = 1'b1;
      w     = wcall(iw, wb, 1'b0);
      iw    = w[1];
      wb    = w[0];
      pend  = 3'd0;
      match = u8c_pkg::MS_IDLE;
    end

    nxt.lines    = nl ? u8c_pkg::bump(st.lines) : st.lines;
    nxt.words    = wb ? u8c_pkg::bump(st.words) : st.words;
    nxt.bytes    = bytes_inc ? u8c_pkg::bump(st.bytes) : st.bytes;
    nxt.conts    = cont_inc ? u8c_pkg::bump(st.conts) : st.conts;
    nxt.cur_len  = nl ? '0 : (len_inc ? u8c_pkg::bump(st.cur_len) : st.cur_len);
    nxt.max_len  = (nl && st.cur_len > st.max_len) ? st.cur_len : st.max_len;
    // every flag in one beat is raised before that beat's newline
    nxt.err      = st.err | fl;
    nxt.err_line = (!st.err && fl) ? st.lines : st.err_line;
    nxt.in_word  = iw;
    nxt.pend     = pend;
    nxt.match    = match;
  end

endmodule
`default_nettype wire

[rtl/utf8_line_word_char_counter.sv]
// top level: input register, counter state update, result snapshot and output register
// result path: end-of-stream state goes to the snapshot register, then the output register
// throughput: one beat per cycle, held only while a result waits on out_tready
// the combinational counter update from one byte back into st_r is the loop that sets this rate
// reset: synchronous active-low rst_n clears counters and valids, config to utf8 decoding
`default_nettype none
module utf8_line_word_char_counter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // data_byte
  input  wire logic                         in_tuser,   // has_byte
  input  wire logic                         in_tlast,   // end_of_stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // line_count, word_count, char_count, longest_line, invalid_seen,
  // first_invalid_line, zero pad
  output logic [u8c_pkg::OUT_W-1:0]         out_tdata,
  input  wire logic                         cfg_we,
  input  wire logic [u8c_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                         cfg_wdata
);

  u8c_pkg::cfg_t   cfg_r;
  u8c_pkg::state_t st_r;
  u8c_pkg::state_t st_nxt;
  u8c_pkg::state_t snap_r;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_has_r;
  logic       in_eos_r;
  logic       snap_v_r;
  logic       out_v_r;
  logic [u8c_pkg::OUT_W-1:0] out_data_r;
  logic [u8c_pkg::OUT_W-1:0] out_data_nxt;

  logic adv1;
  logic snap_adv;
  logic snap_free;

  assign snap_adv  = snap_v_r && (!out_v_r || out_tready);
  assign snap_free = !snap_v_r || snap_adv;
  assign adv1      = in_v_r && (!in_eos_r || snap_free);
  assign in_tready = !in_v_r || adv1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{utf8_enable: 1'b1, chars_as_characters: 1'b0, nbsp_is_space: 1'b0,
                 figure_space_is_space: 1'b0, narrow_nbsp_is_space: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        u8c_pkg::CFG_UTF8:  cfg_r.utf8_enable           <= cfg_wdata;
        u8c_pkg::CFG_CHARS: cfg_r.chars_as_characters   <= cfg_wdata;
        u8c_pkg::CFG_NBSP:  cfg_r.nbsp_is_space         <= cfg_wdata;
        u8c_pkg::CFG_FIGSP: cfg_r.figure_space_is_space <= cfg_wdata;
        u8c_pkg::CFG_NNBSP: cfg_r.narrow_nbsp_is_space  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_has_r  <= in_tuser;
      in_eos_r  <= in_tlast;
    end
  end

  u8c_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .byte_i (in_byte_r),
    .has_i  (in_has_r),
    .eos_i  (in_eos_r),
    .nxt    (st_nxt)
  );

  // running counters and end-of-stream snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      snap_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        if (in_eos_r) st_r <= '0;
        else st_r <= st_nxt;
      end
      if (adv1 && in_eos_r) snap_v_r <= 1'b1;
      else if (snap_adv) snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_eos_r) snap_r <= st_nxt;
  end

  always_comb begin
    u8c_pkg::count_t chars;
    u8c_pkg::count_t longest;
    if (cfg_r.chars_as_characters && cfg_r.utf8_enable && snap_r.bytes >= snap_r.conts)
      chars = snap_r.bytes - snap_r.conts;
    else
      chars = snap_r.bytes;
    longest = (snap_r.cur_len > snap_r.max_len) ? snap_r.cur_len : snap_r.max_len;
    out_data_nxt = '0;
    out_data_nxt[u8c_pkg::LINE_LSB +: u8c_pkg::FIELD_W] = u8c_pkg::clip(snap_r.lines);
    out_data_nxt[u8c_pkg::WORD_LSB +: u8c_pkg::FIELD_W] = u8c_pkg::clip(snap_r.words);
    out_data_nxt[u8c_pkg::CHAR_LSB +: u8c_pkg::FIELD_W] = u8c_pkg::clip(chars);
    out_data_nxt[u8c_pkg::LONG_LSB +: u8c_pkg::FIELD_W] = u8c_pkg::clip(longest);
    out_data_nxt[u8c_pkg::INV_BIT] = snap_r.err;
    out_data_nxt[u8c_pkg::FIL_LSB +: u8c_pkg::FIELD_W] =
      snap_r.err ? u8c_pkg::clip(snap_r.err_line) : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (snap_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_adv) out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

[rtl/u8c_checker.sv]
// port-level checks of the counter's result channel, bound to the top level
`default_nettype none
module u8c_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [u8c_pkg::OUT_W-1:0]     out_tdata
);

  logic [u8c_pkg::FIELD_W-1:0] lines_w;
  logic [u8c_pkg::FIELD_W-1:0] chars_w;
  logic [u8c_pkg::FIELD_W-1:0] long_w;
  logic [u8c_pkg::FIELD_W-1:0] fil_w;

  assign lines_w = out_tdata[u8c_pkg::LINE_LSB +: u8c_pkg::FIELD_W];
  assign chars_w = out_tdata[u8c_pkg::CHAR_LSB +: u8c_pkg::FIELD_W];
  assign long_w  = out_tdata[u8c_pkg::LONG_LSB +: u8c_pkg::FIELD_W];
  assign fil_w   = out_tdata[u8c_pkg::FIL_LSB +: u8c_pkg::FIELD_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_err_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[u8c_pkg::INV_BIT] |-> fil_w == '0)
    else $error("first invalid line set without invalid flag");

  a_longest_le_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> long_w <= chars_w && lines_w <= chars_w)
    else $error("longest line or line count exceeds char count");

endmodule

bind utf8_line_word_char_counter u8c_checker u_chk (.*);
`default_nettype wire
